// ===== rtl/tswin_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tswin_pkg
// Types and constants shared by the markup-stripping line wrapper.
// ----------------------------------------------------------------------------
package tswin_pkg;

   localparam int CHAR_W       = 8;
   localparam int COLUMN_W     = 7;
   localparam int TOTAL_W      = 17;
   localparam int FIRST_W      = 17;
   localparam int LINES_W      = 7;
   localparam int WIDTH_W      = 7;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 17;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 32;
   localparam int RSP_USER_W   = 2;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LT  = 8'h3C;
   localparam logic [CHAR_W-1:0] CHAR_GT  = 8'h3E;

   localparam logic [COLUMN_W-1:0] COLUMN_MAX = 7'h7F;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = 17'h1FFFF;

   localparam logic [FIRST_W-1:0] FIRST_RESET = 17'd0;
   localparam logic [LINES_W-1:0] LINES_RESET = 7'd28;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd66;

   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_VISIBLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_VISIBLE_LINES = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_WIDTH    = 2'd2;

   typedef struct packed {
      logic [FIRST_W-1:0] first_visible;
      logic [LINES_W-1:0] visible_lines;
      logic [WIDTH_W-1:0] line_width;
   } cfg_type;

   // One queued job: an optional line break, an optional character, or end of page.
   typedef struct packed {
      logic               emit_break;
      logic               emit_char;
      logic               done;
      logic [CHAR_W-1:0]  char_code;
      logic [TOTAL_W-1:0] total;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/tswin_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tswin_front
// Classifies page bytes, tracks markup, column and line index, and queues jobs.
// ----------------------------------------------------------------------------
module tswin_front #(
   parameter int MAX_PAGE_LINES = 131072
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tswin_pkg::cfg_type  cfg,
   input  wire logic                accept,
   input  wire logic [tswin_pkg::CHAR_W-1:0] text_byte,
   output tswin_pkg::entry_type     push_entry,
   output logic                     push
);

   localparam int LINE_W = $clog2(MAX_PAGE_LINES);
   localparam int CMP_W  = ((LINE_W > tswin_pkg::TOTAL_W) ? LINE_W : tswin_pkg::TOTAL_W) + 2;
   localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(MAX_PAGE_LINES - 1);

   logic                              markup_ff, markup_in;
   logic [tswin_pkg::COLUMN_W-1:0]    column_ff, column_in;
   logic [LINE_W-1:0]                 line_ff, line_in;

   logic [CMP_W-1:0]  line_ext, next_ext, first_ext, end_ext;
   logic [LINE_W-1:0] line_inc;
   logic              wrap, in_win_now, in_win_next;

   always_comb begin
      line_inc    = (line_ff < LINE_LAST) ? line_ff + LINE_W'(1) : line_ff;
      wrap        = (text_byte == tswin_pkg::CHAR_LF) || (column_ff >= cfg.line_width);
      line_ext    = CMP_W'(line_ff);
      next_ext    = CMP_W'(wrap ? line_inc : line_ff);
      first_ext   = CMP_W'(cfg.first_visible);
      end_ext     = first_ext + CMP_W'(cfg.visible_lines);
      in_win_now  = (line_ext >= first_ext) && (line_ext < end_ext);
      in_win_next = (next_ext >= first_ext) && (next_ext < end_ext);
   end

   always_comb begin
      markup_in             = markup_ff;
      column_in             = column_ff;
      line_in               = line_ff;
      push                  = 1'b0;
      push_entry.emit_break = 1'b0;
      push_entry.emit_char  = 1'b0;
      push_entry.done       = 1'b0;
      push_entry.char_code  = text_byte;
      push_entry.total      = '0;
      if (accept) begin
         priority if (text_byte == tswin_pkg::CHAR_NUL) begin
            push             = 1'b1;
            push_entry.done  = 1'b1;
            push_entry.total = (line_ext > CMP_W'(tswin_pkg::TOTAL_MAX)) ?
                               tswin_pkg::TOTAL_MAX : line_ext[tswin_pkg::TOTAL_W-1:0];
            markup_in        = 1'b0;
            column_in        = '0;
            line_in          = '0;
         end else if (text_byte == tswin_pkg::CHAR_LT) begin
            markup_in = 1'b1;
         end else if (markup_ff) begin
            if (text_byte == tswin_pkg::CHAR_GT) begin
               markup_in = 1'b0;
            end
         end else if (text_byte == tswin_pkg::CHAR_CR) begin
            markup_in = 1'b0;
         end else if (text_byte == tswin_pkg::CHAR_LF) begin
            push_entry.emit_break = in_win_now;
            push                  = in_win_now;
            line_in               = line_inc;
            column_in             = '0;
         end else begin
            push_entry.emit_break = wrap && in_win_now;
            push_entry.emit_char  = in_win_next;
            push                  = (wrap && in_win_now) || in_win_next;
            line_in               = wrap ? line_inc : line_ff;
            if (wrap) begin
               column_in = tswin_pkg::COLUMN_W'(1);
            end else if (column_ff < tswin_pkg::COLUMN_MAX) begin
               column_in = column_ff + tswin_pkg::COLUMN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         markup_ff <= 1'b0;
         column_ff <= '0;
         line_ff   <= '0;
      end else begin
         markup_ff <= markup_in;
         column_ff <= column_in;
         line_ff   <= line_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tswin_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tswin_queue
// Small first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module tswin_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tswin_pkg::entry_type push_entry,
   input  wire logic                 pop,
   output tswin_pkg::entry_type      head,
   output logic                      full,
   output logic                      empty
);

   localparam int PTR_W = $clog2(tswin_pkg::QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   tswin_pkg::entry_type mem_ff [tswin_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == CNT_W'(tswin_pkg::QUEUE_DEPTH));
      empty     = (count_ff == '0);
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tswin_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tswin_back
// Turns queued jobs into result transactions through a registered output.
// ----------------------------------------------------------------------------
module tswin_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tswin_pkg::entry_type head,
   input  wire logic                 empty,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [tswin_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [tswin_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                      rsp_tlast
);

   localparam int PAD_W = tswin_pkg::RSP_DATA_W - tswin_pkg::CHAR_W - tswin_pkg::TOTAL_W;

   logic                              valid_ff, valid_in;
   logic                              split_ff, split_in;
   logic [tswin_pkg::CHAR_W-1:0]      char_ff, char_in;
   logic [tswin_pkg::TOTAL_W-1:0]     total_ff, total_in;
   logic                              cvalid_ff, cvalid_in;
   logic                              done_ff, done_in;
   logic                              last_ff, last_in;
   logic                              slot_free, load, two;

   always_comb begin
      slot_free = !valid_ff || rsp_tready;
      load      = slot_free && !empty;
      two       = head.emit_break && head.emit_char;
      pop       = load && !(two && !split_ff);
      valid_in  = load ? 1'b1 : (valid_ff && !rsp_tready);
      split_in  = split_ff;
      char_in   = char_ff;
      total_in  = total_ff;
      cvalid_in = cvalid_ff;
      done_in   = done_ff;
      last_in   = last_ff;
      if (load) begin
         split_in  = two && !split_ff;
         total_in  = head.total;
         done_in   = head.done;
         cvalid_in = !head.done;
         last_in   = pop;
         if (head.done) begin
            char_in = tswin_pkg::CHAR_NUL;
         end else if (head.emit_break && !split_ff) begin
            char_in = tswin_pkg::CHAR_LF;
         end else begin
            char_in = head.char_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         split_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         split_ff <= split_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff   <= char_in;
      total_ff  <= total_in;
      cvalid_ff <= cvalid_in;
      done_ff   <= done_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, total_ff, char_ff};
   assign rsp_tuser  = {done_ff, cvalid_ff};
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// ===== rtl/tag_strip_line_wrap_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tag_strip_line_wrap_window
// Strips markup from a page byte stream and wraps it into a window of lines.
// ----------------------------------------------------------------------------
// Page bytes arrive on the req_ channel, one byte per transaction. Results
// leave on the rsp_ channel: tdata holds the character and the line total,
// tuser the character-valid and page-done flags, and tlast marks the final
// result caused by one byte. Bytes that give no result are simply absorbed.
// The csr_ channel writes first_visible, visible_lines and line_width; it is
// always ready and is meant to be used only while the block is idle.
// The front end takes one byte per cycle while the queue has room. Each
// result goes through the job queue and then the output register. A forced
// wrap inside the window can give two results from one byte; the four-entry
// job queue absorbs these and any stall on rsp_tready, and req_tready falls
// only once that queue is full. Reset empties the queue and output register,
// clears the scan state and returns the registers to 0, 28 and 66.
// ----------------------------------------------------------------------------
module tag_strip_line_wrap_window #(
   parameter int MAX_PAGE_LINES = 131072
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [tswin_pkg::REQ_DATA_W-1:0]      req_tdata,  // text_byte
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [tswin_pkg::RSP_DATA_W-1:0]           rsp_tdata,  // out_char, line_total
   output logic [tswin_pkg::RSP_USER_W-1:0]           rsp_tuser,  // char_valid, page_done
   output logic                                       rsp_tlast,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [tswin_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [tswin_pkg::CSR_DATA_W-1:0]      csr_data
);

   tswin_pkg::cfg_type   cfg_ff, cfg_in;
   tswin_pkg::entry_type push_entry, head;
   logic                 push, pop, full, empty, accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            tswin_pkg::CSR_FIRST_VISIBLE:
               cfg_in.first_visible = csr_data[tswin_pkg::FIRST_W-1:0];
            tswin_pkg::CSR_VISIBLE_LINES:
               cfg_in.visible_lines = csr_data[tswin_pkg::LINES_W-1:0];
            tswin_pkg::CSR_LINE_WIDTH:
               cfg_in.line_width = csr_data[tswin_pkg::WIDTH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_visible <= tswin_pkg::FIRST_RESET;
         cfg_ff.visible_lines <= tswin_pkg::LINES_RESET;
         cfg_ff.line_width    <= tswin_pkg::WIDTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tswin_front #(
      .MAX_PAGE_LINES (MAX_PAGE_LINES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .text_byte  (req_tdata[tswin_pkg::CHAR_W-1:0]),
      .push_entry (push_entry),
      .push       (push)
   );

   tswin_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   tswin_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the markup-stripping line wrapper.
// ----------------------------------------------------------------------------
// A table of directed rows runs first. It covers markup, nested markup,
// dropped carriage returns, forced wraps, a zero line width, an empty window,
// the largest window and a register change part-way through a page. Random
// pages follow under a range of window settings. Every accepted byte passes
// through a local model of the wrapper, and each result transaction is
// checked against the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [tswin_pkg::CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned PAGE_LINE_LIMIT = 131072;
   localparam int LATENCY_SLACK  = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 150;

   typedef struct packed {
      logic [tswin_pkg::CHAR_W-1:0]  glyph;
      logic                          shown;
      logic                          done;
      logic [tswin_pkg::TOTAL_W-1:0] total;
      logic                          tail;
   } glyph_type;

   typedef struct {
      bit                               is_csr;
      logic [tswin_pkg::CSR_ADDR_W-1:0] addr;
      logic [tswin_pkg::CSR_DATA_W-1:0] value;
      int                               n_typed;
      glyph_type                        typed;
   } row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [tswin_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [tswin_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [tswin_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tswin_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [tswin_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int unsigned win_first  = 32'(tswin_pkg::FIRST_RESET);
   int unsigned win_count  = 32'(tswin_pkg::LINES_RESET);
   int unsigned wrap_width = 32'(tswin_pkg::WIDTH_RESET);
   bit          in_tag     = 1'b0;
   int unsigned col        = 0;
   int unsigned line_no    = 0;

   glyph_type pending_glyphs[$];
   int        mismatch_count = 0;
   int        quiet_cycles   = 0;
   bit        steady         = 1'b0;
   bit        row_typed      = 1'b0;
   bit        row_has_exp    = 1'b0;
   glyph_type row_exp        = '0;

   tag_strip_line_wrap_window u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 35);
   end

   function automatic glyph_type mk_result(input logic [tswin_pkg::CHAR_W-1:0] c,
                                           input logic v, input logic d,
                                           input logic [tswin_pkg::TOTAL_W-1:0] t,
                                           input logic last);
      glyph_type g;
      g.glyph = c;
      g.shown = v;
      g.done  = d;
      g.total = t;
      g.tail  = last;
      return g;
   endfunction

   function automatic bit line_shown(input int unsigned ln);
      return ln >= win_first && ln < win_first + win_count;
   endfunction

   function automatic void store_csr(input logic [tswin_pkg::CSR_ADDR_W-1:0] a,
                                     input logic [tswin_pkg::CSR_DATA_W-1:0] d);
      case (a)
         tswin_pkg::CSR_FIRST_VISIBLE: win_first = 32'(d);
         tswin_pkg::CSR_VISIBLE_LINES: win_count = 32'(d[tswin_pkg::LINES_W-1:0]);
         tswin_pkg::CSR_LINE_WIDTH:    wrap_width = 32'(d[tswin_pkg::WIDTH_W-1:0]);
         default: ;
      endcase
   endfunction

   // Advances the scan state by one byte; the results are queued when keep is set.
   function automatic void wrap_text_byte(input logic [tswin_pkg::CHAR_W-1:0] b,
                                          input bit keep);
      glyph_type   outs[$];
      int unsigned clamp;
      if (b == tswin_pkg::CHAR_NUL) begin
         clamp = (line_no > 32'(tswin_pkg::TOTAL_MAX)) ? 32'(tswin_pkg::TOTAL_MAX) : line_no;
         outs.push_back(mk_result(tswin_pkg::CHAR_NUL, 1'b0, 1'b1,
                                  tswin_pkg::TOTAL_W'(clamp), 1'b0));
         in_tag  = 1'b0;
         col     = 0;
         line_no = 0;
      end else if (b == tswin_pkg::CHAR_LT) begin
         in_tag = 1'b1;
      end else if (in_tag) begin
         if (b == tswin_pkg::CHAR_GT) in_tag = 1'b0;
      end else if (b != tswin_pkg::CHAR_CR) begin
         if (b == tswin_pkg::CHAR_LF || col >= wrap_width) begin
            if (line_shown(line_no))
               outs.push_back(mk_result(tswin_pkg::CHAR_LF, 1'b1, 1'b0, '0, 1'b0));
            if (line_no < PAGE_LINE_LIMIT - 1) line_no++;
            col = 0;
         end
         if (b != tswin_pkg::CHAR_LF) begin
            if (line_shown(line_no)) outs.push_back(mk_result(b, 1'b1, 1'b0, '0, 1'b0));
            if (col < 32'(tswin_pkg::COLUMN_MAX)) col++;
         end
      end
      if (outs.size() > 0) outs[outs.size()-1].tail = 1'b1;
      if (keep) foreach (outs[k]) pending_glyphs.push_back(outs[k]);
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatch_count < 100)
         $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      glyph_type want;
      bit        moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            store_csr(csr_addr, csr_data);
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            wrap_text_byte(req_tdata, !row_typed);
            if (row_typed && row_has_exp) pending_glyphs.push_back(row_exp);
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (pending_glyphs.size() == 0) begin
               flag_mismatch("result with no expectation", rsp_tdata, '0);
            end else begin
               want = pending_glyphs.pop_front();
               if (rsp_tdata[7:0] !== want.glyph)
                  flag_mismatch("out_char", 32'(rsp_tdata[7:0]), 32'(want.glyph));
               if (rsp_tdata[24:8] !== want.total)
                  flag_mismatch("line_total", 32'(rsp_tdata[24:8]), 32'(want.total));
               if (rsp_tuser[0] !== want.shown)
                  flag_mismatch("char_valid", 32'(rsp_tuser[0]), 32'(want.shown));
               if (rsp_tuser[1] !== want.done)
                  flag_mismatch("page_done", 32'(rsp_tuser[1]), 32'(want.done));
               if (rsp_tlast !== want.tail)
                  flag_mismatch("last_of_run", 32'(rsp_tlast), 32'(want.tail));
            end
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Entered and left at a falling edge.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [tswin_pkg::CSR_ADDR_W-1:0] a,
                            input logic [tswin_pkg::CSR_DATA_W-1:0] d);
      settle();
      csr_valid <= 1'b1;
      csr_addr  <= a;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_byte(input logic [tswin_pkg::CHAR_W-1:0] b, input int n_typed,
                            input glyph_type typed);
      int gap;
      gap = (steady || $urandom_range(99) >= 35) ? 0 : $urandom_range(1, 2);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed   = (n_typed >= 0);
      row_has_exp = (n_typed == 1);
      row_exp     = typed;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic pick_window();
      int                               r;
      logic [tswin_pkg::CSR_DATA_W-1:0] first, lines, width;
      r = $urandom_range(99);
      if (r < 60) first = tswin_pkg::CSR_DATA_W'($urandom_range(0, 6));
      else if (r < 75) first = '0;
      else if (r < 85) first = tswin_pkg::TOTAL_MAX;
      else first = tswin_pkg::CSR_DATA_W'($urandom);
      r = $urandom_range(99);
      if (r < 70) lines = tswin_pkg::CSR_DATA_W'($urandom_range(1, 12));
      else if (r < 80) lines = '0;
      else if (r < 90) lines = tswin_pkg::CSR_DATA_W'(127);
      else lines = tswin_pkg::CSR_DATA_W'($urandom_range(0, 127));
      r = $urandom_range(99);
      if (r < 60) width = tswin_pkg::CSR_DATA_W'($urandom_range(1, 20));
      else if (r < 70) width = '0;
      else if (r < 80) width = tswin_pkg::CSR_DATA_W'(127);
      else width = tswin_pkg::CSR_DATA_W'($urandom_range(0, 127));
      if ($urandom_range(3) == 0) lines[16:7] = 10'($urandom);
      if ($urandom_range(3) == 0) width[16:7] = 10'($urandom);
      write_csr(tswin_pkg::CSR_FIRST_VISIBLE, first);
      write_csr(tswin_pkg::CSR_VISIBLE_LINES, lines);
      write_csr(tswin_pkg::CSR_LINE_WIDTH, width);
      if ($urandom_range(3) == 0) write_csr(CSR_UNUSED, tswin_pkg::CSR_DATA_W'($urandom));
   endtask

   function automatic row_type byte_row(input logic [tswin_pkg::CHAR_W-1:0] b,
                                        input int n_typed, input glyph_type typed);
      row_type r;
      r.is_csr  = 1'b0;
      r.addr    = '0;
      r.value   = tswin_pkg::CSR_DATA_W'(b);
      r.n_typed = n_typed;
      r.typed   = typed;
      return r;
   endfunction

   function automatic row_type csr_row(input logic [tswin_pkg::CSR_ADDR_W-1:0] a,
                                       input logic [tswin_pkg::CSR_DATA_W-1:0] d);
      row_type r;
      r.is_csr  = 1'b1;
      r.addr    = a;
      r.value   = d;
      r.n_typed = -1;
      r.typed   = '0;
      return r;
   endfunction

   initial begin : stimulus
      row_type                      script[$];
      int                           ph, sent, len, pick;
      bit                           paused;
      logic [tswin_pkg::CHAR_W-1:0] c;

      script.push_back(byte_row(tswin_pkg::CHAR_NUL, 1,
                                mk_result(tswin_pkg::CHAR_NUL, 1'b0, 1'b1, '0, 1'b1)));
      script.push_back(byte_row(8'h41, 1, mk_result(8'h41, 1'b1, 1'b0, '0, 1'b1)));
      script.push_back(byte_row(tswin_pkg::CHAR_LT, 0, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_LT, 0, '0));
      script.push_back(byte_row(8'h71, 0, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_GT, 0, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_CR, 0, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_GT, -1, '0));
      script.push_back(byte_row(8'hFF, -1, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_LF, 1,
                                mk_result(tswin_pkg::CHAR_LF, 1'b1, 1'b0, '0, 1'b1)));
      script.push_back(csr_row(tswin_pkg::CSR_LINE_WIDTH, '0));
      script.push_back(byte_row(8'h61, -1, '0));
      script.push_back(byte_row(8'h62, -1, '0));
      script.push_back(csr_row(tswin_pkg::CSR_VISIBLE_LINES, '0));
      script.push_back(byte_row(8'h63, 0, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_LF, 0, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_NUL, -1, '0));
      script.push_back(csr_row(CSR_UNUSED, tswin_pkg::CSR_DATA_W'(5)));
      script.push_back(csr_row(tswin_pkg::CSR_FIRST_VISIBLE, tswin_pkg::TOTAL_MAX));
      script.push_back(csr_row(tswin_pkg::CSR_VISIBLE_LINES, tswin_pkg::CSR_DATA_W'(127)));
      script.push_back(csr_row(tswin_pkg::CSR_LINE_WIDTH, tswin_pkg::CSR_DATA_W'(127)));
      script.push_back(byte_row(8'h01, 0, '0));
      script.push_back(byte_row(8'h7F, 0, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_LF, 0, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_NUL, -1, '0));
      script.push_back(csr_row(tswin_pkg::CSR_FIRST_VISIBLE, '0));
      script.push_back(csr_row(tswin_pkg::CSR_VISIBLE_LINES, tswin_pkg::CSR_DATA_W'(2)));
      script.push_back(csr_row(tswin_pkg::CSR_LINE_WIDTH, tswin_pkg::CSR_DATA_W'(3)));
      script.push_back(byte_row(8'h78, -1, '0));
      script.push_back(byte_row(8'h79, -1, '0));
      script.push_back(byte_row(8'h7A, -1, '0));
      script.push_back(byte_row(8'h77, -1, '0));
      script.push_back(csr_row(tswin_pkg::CSR_LINE_WIDTH, tswin_pkg::CSR_DATA_W'(1)));
      script.push_back(byte_row(8'h6B, -1, '0));
      script.push_back(byte_row(tswin_pkg::CHAR_NUL, -1, '0));

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[k]) begin
         if (script[k].is_csr) write_csr(script[k].addr, script[k].value);
         else push_byte(script[k].value[tswin_pkg::CHAR_W-1:0], script[k].n_typed,
                        script[k].typed);
      end

      paused = 1'b0;
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         pick_window();
         steady = (ph == 3);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (ph == 6 && !paused && sent >= PHASE_ITEMS / 2) begin
               settle();
               paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
               len = $urandom_range(1, 12);
               repeat (len) begin
                  c = tswin_pkg::CHAR_W'($urandom_range(32, 126));
                  if (c == tswin_pkg::CHAR_LT) c = tswin_pkg::CHAR_GT;
                  push_byte(c, -1, '0);
                  sent++;
               end
            end else if (pick < 70) begin
               if ($urandom_range(1) == 1) begin
                  push_byte(tswin_pkg::CHAR_CR, -1, '0);
                  sent++;
               end
               push_byte(tswin_pkg::CHAR_LF, -1, '0);
               sent++;
            end else if (pick < 82) begin
               push_byte(tswin_pkg::CHAR_LT, -1, '0);
               sent++;
               len = $urandom_range(0, 6);
               repeat (len) begin
                  c = tswin_pkg::CHAR_W'($urandom_range(32, 126));
                  if (c == tswin_pkg::CHAR_GT) c = tswin_pkg::CHAR_LT;
                  push_byte(c, -1, '0);
                  sent++;
               end
               if ($urandom_range(4) != 0) begin
                  push_byte(tswin_pkg::CHAR_GT, -1, '0);
                  sent++;
               end
            end else if (pick < 92) begin
               len = $urandom_range(1, 4);
               repeat (len) begin
                  push_byte(tswin_pkg::CHAR_W'($urandom_range(1, 255)), -1, '0);
                  sent++;
               end
            end else if (pick < 96) begin
               push_byte(tswin_pkg::CHAR_NUL, -1, '0);
               sent++;
            end else begin
               push_byte(tswin_pkg::CHAR_CR, -1, '0);
               sent++;
            end
         end
      end
      push_byte(tswin_pkg::CHAR_NUL, -1, '0);
      steady = 1'b0;

      settle();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tswin_pkg.sv
rtl/tswin_front.sv
rtl/tswin_queue.sv
rtl/tswin_back.sv
rtl/tag_strip_line_wrap_window.sv
test/tb.sv
